[design/tba_pkg.sv]
// ----------------------------------------------------------------------------
// tba_pkg: shared constants and types for the target bearing block
// Register indexes, angle limits, CORDIC widths and the arc tangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package tba_pkg;

   localparam int FACING_BITS   = 16;
   localparam int CSR_IDX_BITS  = 8;
   localparam int ANGLE_BITS    = 16;
   localparam int NORM_BITS     = 21;  // direction magnitude after normalization
   localparam int SQ_SHIFT      = 20;  // extra scale of the squared length
   localparam int ROOT_BITS     = 32;
   localparam int ANG_NORM_BITS = 30;  // cordic operands after normalization
   localparam int CORDIC_BITS   = 33;
   localparam int CORDIC_STAGES = 20;
   localparam int ZW            = 28;
   localparam int ANG_DROP      = 8;   // 2^-16 degree down to q8.8
   localparam int ANG_LATENCY   = CORDIC_STAGES + 5;

   typedef logic signed [CORDIC_BITS-1:0] cordic_type;
   typedef logic signed [ZW-1:0]          zang_type;

   localparam logic [CSR_IDX_BITS-1:0] CSR_FACING_X = 8'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FACING_Y = 8'd1;

   localparam logic [ANGLE_BITS-1:0] ANGLE_MAX   = 16'd46080;
   localparam logic [ANGLE_BITS-1:0] ANGLE_RIGHT = 16'd23040;
   localparam zang_type ZANG_90   = 28'sd5898240;
   localparam zang_type ZANG_HALF = 28'sd128;

   function automatic int dir_latency(input int frac_bits);
      return frac_bits + 39;
   endfunction

   // atan(2^-i) in units of 2^-16 degree
   function automatic zang_type atan_deg(input int idx);
      zang_type v;
      case (idx)
         0:  v = 28'sd2949120;
         1:  v = 28'sd1740967;
         2:  v = 28'sd919879;
         3:  v = 28'sd466945;
         4:  v = 28'sd234379;
         5:  v = 28'sd117304;
         6:  v = 28'sd58666;
         7:  v = 28'sd29335;
         8:  v = 28'sd14668;
         9:  v = 28'sd7334;
         10: v = 28'sd3667;
         11: v = 28'sd1833;
         12: v = 28'sd917;
         13: v = 28'sd458;
         14: v = 28'sd229;
         15: v = 28'sd115;
         16: v = 28'sd57;
         17: v = 28'sd29;
         18: v = 28'sd14;
         19: v = 28'sd7;
         default: v = 28'sd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

[design/tba_if.sv]
// ----------------------------------------------------------------------------
// tba_if: channel interfaces of the target bearing block
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface tba_req_if #(parameter int COORD_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] own_x;
   logic signed [COORD_BITS-1:0] own_y;
   logic signed [COORD_BITS-1:0] target_x;
   logic signed [COORD_BITS-1:0] target_y;
   modport source (output valid, own_x, own_y, target_x, target_y, input ready);
   modport sink   (input valid, own_x, own_y, target_x, target_y, output ready);
endinterface

interface tba_rsp_if #(parameter int DIR_BITS = 16);
   logic                                 valid;
   logic                                 ready;
   logic signed [DIR_BITS-1:0]           dir_x;
   logic signed [DIR_BITS-1:0]           dir_y;
   logic [tba_pkg::ANGLE_BITS-1:0]       angle_deg;
   logic                                 is_right;
   modport source (output valid, dir_x, dir_y, angle_deg, is_right, input ready);
   modport sink   (input valid, dir_x, dir_y, angle_deg, is_right, output ready);
endinterface

interface tba_csr_if;
   logic                               valid;
   logic                               ready;
   logic [tba_pkg::CSR_IDX_BITS-1:0]   index;
   logic [tba_pkg::FACING_BITS-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/tba_dir.sv]
// ----------------------------------------------------------------------------
// tba_dir: unit direction pipeline
// Normalize, square, pipelined square root and two restoring dividers.
// ----------------------------------------------------------------------------
`default_nettype none

module tba_dir #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 14
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic signed [COORD_BITS:0]  dx,
   input  logic signed [COORD_BITS:0]  dy,
   output logic signed [FRAC_BITS+1:0] ux,
   output logic signed [FRAC_BITS+1:0] uy
);

   localparam int DW    = COORD_BITS + 1;
   localparam int NB    = tba_pkg::NORM_BITS;
   localparam int NW    = (COORD_BITS > NB) ? COORD_BITS : NB;
   localparam int NSTEP = $clog2(NW);
   localparam int QW    = FRAC_BITS + 1;
   localparam int OW    = FRAC_BITS + 2;
   localparam int SH    = FRAC_BITS + 10;
   localparam int NUMW  = FRAC_BITS + 33;
   localparam int RB    = tba_pkg::ROOT_BITS;
   localparam int VB    = 2 * RB;

   typedef struct packed {
      logic [NB-1:0] na;
      logic [NB-1:0] nb;
      logic          sx;
      logic          sy;
      logic          zero;
   } dside_type;

   // magnitudes
   logic [DW-1:0] absx_w, absy_w;
   logic [NW-1:0] ma1_ff, mb1_ff;
   logic          sx1_ff, sy1_ff, zero1_ff;

   assign absx_w = dx[DW-1] ? DW'(-dx) : DW'(dx);
   assign absy_w = dy[DW-1] ? DW'(-dy) : DW'(dy);

   always_ff @(posedge clock) begin
      if (en) begin
         ma1_ff   <= NW'(absx_w[COORD_BITS-1:0]);
         mb1_ff   <= NW'(absy_w[COORD_BITS-1:0]);
         sx1_ff   <= dx[DW-1];
         sy1_ff   <= dy[DW-1];
         zero1_ff <= (dx == '0) && (dy == '0);
      end
   end

   // left justify, keep top bits (truncates when the vector is large)
   logic [NW-1:0] na2_w, nb2_w;
   dside_type     side2_ff;

   always_comb begin
      na2_w = ma1_ff;
      nb2_w = mb1_ff;
      for (int k = NSTEP - 1; k >= 0; k--) begin
         if (((na2_w | nb2_w) >> (NW - (1 << k))) == '0) begin
            na2_w = na2_w << (1 << k);
            nb2_w = nb2_w << (1 << k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side2_ff.na   <= na2_w[NW-1 -: NB];
         side2_ff.nb   <= nb2_w[NW-1 -: NB];
         side2_ff.sx   <= sx1_ff;
         side2_ff.sy   <= sy1_ff;
         side2_ff.zero <= zero1_ff;
      end
   end

   // squares
   logic [2*NB-1:0] sqa3_ff, sqb3_ff;
   dside_type       side3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sqa3_ff  <= (2*NB)'(side2_ff.na) * (2*NB)'(side2_ff.na);
         sqb3_ff  <= (2*NB)'(side2_ff.nb) * (2*NB)'(side2_ff.nb);
         side3_ff <= side2_ff;
      end
   end

   // square root, one result bit per stage
   logic [VB-1:0] sv_ff [0:RB-1];
   logic [VB-1:0] sr_ff [0:RB];
   dside_type     sside_ff [0:RB];
   logic [2*NB:0] len2_w;

   assign len2_w = (2*NB+1)'(sqa3_ff) + (2*NB+1)'(sqb3_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         sv_ff[0]    <= VB'(len2_w) << tba_pkg::SQ_SHIFT;
         sr_ff[0]    <= '0;
         sside_ff[0] <= side3_ff;
      end
   end

   for (genvar j = 0; j < RB; j++) begin : g_sqrt
      localparam logic [VB-1:0] BIT = VB'(1) << (2 * (RB - 1 - j));
      logic [VB-1:0] t_w;
      logic          take_w;
      assign t_w    = sr_ff[j] + BIT;
      assign take_w = (sv_ff[j] >= t_w);

      always_ff @(posedge clock) begin
         if (en) begin
            sr_ff[j+1]    <= take_w ? ((sr_ff[j] >> 1) + BIT) : (sr_ff[j] >> 1);
            sside_ff[j+1] <= sside_ff[j];
         end
      end

      if (j < RB - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               sv_ff[j+1] <= take_w ? (sv_ff[j] - t_w) : sv_ff[j];
            end
         end
      end
   end

   // rounded numerators, then restoring division
   logic [RB-1:0]   root_w;
   logic [NUMW-1:0] rema_ff [0:QW];
   logic [NUMW-1:0] remb_ff [0:QW];
   logic [RB-1:0]   dv_ff   [0:QW-1];
   logic [QW-1:0]   qa_ff   [0:QW];
   logic [QW-1:0]   qb_ff   [0:QW];
   dside_type       qside_ff [0:QW];

   assign root_w = sr_ff[RB][RB-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         rema_ff[0]  <= (NUMW'(sside_ff[RB].na) << SH) + NUMW'(root_w >> 1);
         remb_ff[0]  <= (NUMW'(sside_ff[RB].nb) << SH) + NUMW'(root_w >> 1);
         dv_ff[0]    <= root_w;
         qa_ff[0]    <= '0;
         qb_ff[0]    <= '0;
         qside_ff[0] <= sside_ff[RB];
      end
   end

   for (genvar i = 0; i < QW; i++) begin : g_div
      localparam int B = QW - 1 - i;
      logic [NUMW-1:0] sub_w;
      logic            ta_w, tb_w;
      assign sub_w = NUMW'(dv_ff[i]) << B;
      assign ta_w  = (rema_ff[i] >= sub_w);
      assign tb_w  = (remb_ff[i] >= sub_w);

      always_ff @(posedge clock) begin
         if (en) begin
            rema_ff[i+1]  <= ta_w ? (rema_ff[i] - sub_w) : rema_ff[i];
            remb_ff[i+1]  <= tb_w ? (remb_ff[i] - sub_w) : remb_ff[i];
            qa_ff[i+1]    <= qa_ff[i] | (QW'(ta_w) << B);
            qb_ff[i+1]    <= qb_ff[i] | (QW'(tb_w) << B);
            qside_ff[i+1] <= qside_ff[i];
         end
      end

      if (i < QW - 1) begin : g_dv
         always_ff @(posedge clock) begin
            if (en) begin
               dv_ff[i+1] <= dv_ff[i];
            end
         end
      end
   end

   // sign and zero vector
   logic signed [OW-1:0] ux_ff, uy_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (qside_ff[QW].zero) begin
            ux_ff <= '0;
            uy_ff <= '0;
         end else begin
            ux_ff <= qside_ff[QW].sx ? -OW'(qa_ff[QW]) : OW'(qa_ff[QW]);
            uy_ff <= qside_ff[QW].sy ? -OW'(qb_ff[QW]) : OW'(qb_ff[QW]);
         end
      end
   end

   assign ux = ux_ff;
   assign uy = uy_ff;

endmodule

`default_nettype wire

[design/tba_ang.sv]
// ----------------------------------------------------------------------------
// tba_ang: angle and side pipeline
// Dot and cross products, quadrant fold, normalization, vectoring CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none

module tba_ang #(
   parameter int COORD_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   en,
   input  logic signed [COORD_BITS:0]             dx,
   input  logic signed [COORD_BITS:0]             dy,
   input  logic signed [tba_pkg::FACING_BITS-1:0] fx,
   input  logic signed [tba_pkg::FACING_BITS-1:0] fy,
   output logic [tba_pkg::ANGLE_BITS-1:0]         angle,
   output logic                                   is_right
);

   localparam int PW    = COORD_BITS + 1 + tba_pkg::FACING_BITS;
   localparam int SW    = PW + 1;
   localparam int NB    = tba_pkg::ANG_NORM_BITS;
   localparam int AW    = (SW > NB) ? SW : NB;
   localparam int NSTEP = $clog2(AW);
   localparam int CW    = tba_pkg::CORDIC_BITS;
   localparam int NS    = tba_pkg::CORDIC_STAGES;
   localparam int ZW    = tba_pkg::ZW;

   typedef struct packed {
      logic right;
      logic spec;
   } aside_type;

   // products
   logic signed [PW-1:0] pdx1_ff, pdy1_ff, pcx1_ff, pcy1_ff;
   logic                 spec1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pdx1_ff  <= PW'(fx) * PW'(dx);
         pdy1_ff  <= PW'(fy) * PW'(dy);
         pcy1_ff  <= PW'(fx) * PW'(dy);
         pcx1_ff  <= PW'(fy) * PW'(dx);
         spec1_ff <= ((dx == '0) && (dy == '0)) || ((fx == '0) && (fy == '0));
      end
   end

   // dot and cross
   logic signed [SW-1:0] dot2_ff, cross2_ff;
   logic                 spec2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         dot2_ff   <= SW'(pdx1_ff) + SW'(pdy1_ff);
         cross2_ff <= SW'(pcy1_ff) - SW'(pcx1_ff);
         spec2_ff  <= spec1_ff;
      end
   end

   // fold a negative dot into the first quadrant with a 90 degree offset
   logic [SW-1:0] dmag_w, cmag_w;
   logic [AW-1:0] x3_ff, y3_ff;
   tba_pkg::zang_type z3_ff;
   aside_type     side3_ff;

   assign dmag_w = dot2_ff[SW-1]   ? SW'(-dot2_ff)   : SW'(dot2_ff);
   assign cmag_w = cross2_ff[SW-1] ? SW'(-cross2_ff) : SW'(cross2_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         if (dot2_ff[SW-1]) begin
            x3_ff <= AW'(cmag_w);
            y3_ff <= AW'(dmag_w);
            z3_ff <= tba_pkg::ZANG_90;
         end else begin
            x3_ff <= AW'(dmag_w);
            y3_ff <= AW'(cmag_w);
            z3_ff <= '0;
         end
         side3_ff.right <= !cross2_ff[SW-1];
         side3_ff.spec  <= spec2_ff;
      end
   end

   // normalize so the larger operand has its top bit at NB-1
   logic [AW-1:0] xn_w, yn_w;

   always_comb begin
      xn_w = x3_ff;
      yn_w = y3_ff;
      for (int k = NSTEP - 1; k >= 0; k--) begin
         if (((xn_w | yn_w) >> (AW - (1 << k))) == '0) begin
            xn_w = xn_w << (1 << k);
            yn_w = yn_w << (1 << k);
         end
      end
   end

   tba_pkg::cordic_type cx_ff [0:NS];
   tba_pkg::cordic_type cy_ff [0:NS];
   tba_pkg::zang_type   cz_ff [0:NS];
   aside_type           cside_ff [0:NS];

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff[0]    <= CW'(xn_w[AW-1 -: NB]);
         cy_ff[0]    <= CW'(yn_w[AW-1 -: NB]);
         cz_ff[0]    <= z3_ff;
         cside_ff[0] <= side3_ff;
      end
   end

   // vectoring cordic, one rotation per stage
   for (genvar i = 0; i < NS; i++) begin : g_cordic
      localparam tba_pkg::zang_type ATAN = tba_pkg::atan_deg(i);
      tba_pkg::cordic_type xs_w, ys_w;
      assign xs_w = cx_ff[i] >>> i;
      assign ys_w = cy_ff[i] >>> i;

      always_ff @(posedge clock) begin
         if (en) begin
            if (!cy_ff[i][CW-1]) begin
               cx_ff[i+1] <= cx_ff[i] + ys_w;
               cy_ff[i+1] <= cy_ff[i] - xs_w;
               cz_ff[i+1] <= cz_ff[i] + ATAN;
            end else begin
               cx_ff[i+1] <= cx_ff[i] - ys_w;
               cy_ff[i+1] <= cy_ff[i] + xs_w;
               cz_ff[i+1] <= cz_ff[i] - ATAN;
            end
            cside_ff[i+1] <= cside_ff[i];
         end
      end
   end

   // round to q8.8 and clamp; a zero difference or zero facing gives 90 degrees
   localparam tba_pkg::zang_type ZMAX = ZW'(tba_pkg::ANGLE_MAX);
   tba_pkg::zang_type q_w;
   logic [tba_pkg::ANGLE_BITS-1:0] angle_ff;
   logic                           right_ff;

   assign q_w = (cz_ff[NS] + tba_pkg::ZANG_HALF) >>> tba_pkg::ANG_DROP;

   always_ff @(posedge clock) begin
      if (en) begin
         if (cside_ff[NS].spec) begin
            angle_ff <= tba_pkg::ANGLE_RIGHT;
         end else if (q_w[ZW-1]) begin
            angle_ff <= '0;
         end else if (q_w > ZMAX) begin
            angle_ff <= tba_pkg::ANGLE_MAX;
         end else begin
            angle_ff <= q_w[tba_pkg::ANGLE_BITS-1:0];
         end
         right_ff <= cside_ff[NS].right;
      end
   end

   assign angle    = angle_ff;
   assign is_right = right_ff;

endmodule

`default_nettype wire

[design/target_bearing_angle_side.sv]
// ----------------------------------------------------------------------------
// target_bearing_angle_side: bearing of a target relative to a facing vector
// Unit direction, unsigned angle and side bit for observer/target pairs.
// ----------------------------------------------------------------------------
// One request is taken per clock while req_ch.ready is high. Each request
// passes through the entry stage, which forms the position difference, then
// the direction pipeline (a 32 stage square root followed by FRAC_BITS + 1
// divider stages), then the output register. The angle path (products, fold,
// 20 stage CORDIC) is shorter and is delayed to line up. The whole pipeline
// advances together; while a response waits unclaimed in the output register,
// the pipeline holds and req_ch.ready is low. The facing registers reset to
// (1, 0) and are written through csr_ch, which is always ready; other indexes
// are dropped. Write them only while the pipeline is empty.
`default_nettype none

module target_bearing_angle_side #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 14
) (
   input  logic       clock,
   input  logic       reset,
   tba_req_if.sink    req_ch,
   tba_rsp_if.source  rsp_ch,
   tba_csr_if.sink    csr_ch
);

   localparam int DW  = COORD_BITS + 1;
   localparam int OW  = FRAC_BITS + 2;
   localparam int FB  = tba_pkg::FACING_BITS;
   localparam int LD  = tba_pkg::dir_latency(FRAC_BITS);
   localparam int PAD = LD - tba_pkg::ANG_LATENCY;

   // facing registers
   logic signed [FB-1:0] facing_x_ff, facing_y_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         facing_x_ff <= FB'(1);
         facing_y_ff <= '0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            tba_pkg::CSR_FACING_X: facing_x_ff <= csr_ch.data;
            tba_pkg::CSR_FACING_Y: facing_y_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // global advance: the output register is empty or being drained
   logic en;
   logic rsp_valid_ff;

   assign en           = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   // entry stage: position difference and a snapshot of the facing vector
   logic signed [DW-1:0] dx0_ff, dy0_ff;
   logic signed [FB-1:0] fx0_ff, fy0_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         dx0_ff <= DW'(req_ch.target_x) - DW'(req_ch.own_x);
         dy0_ff <= DW'(req_ch.target_y) - DW'(req_ch.own_y);
         fx0_ff <= facing_x_ff;
         fy0_ff <= facing_y_ff;
      end
   end

   // valid bits travel alongside the payload
   logic vld_ff [0:LD];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_ch.valid;
      end
   end

   for (genvar k = 1; k <= LD; k++) begin : g_vld
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // direction path
   logic signed [OW-1:0] ux_w, uy_w;

   tba_dir #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dir (
      .clock (clock),
      .en    (en),
      .dx    (dx0_ff),
      .dy    (dy0_ff),
      .ux    (ux_w),
      .uy    (uy_w)
   );

   // angle and side path
   logic [tba_pkg::ANGLE_BITS-1:0] angle_w;
   logic                           right_w;

   tba_ang #(
      .COORD_BITS (COORD_BITS)
   ) u_ang (
      .clock    (clock),
      .en       (en),
      .dx       (dx0_ff),
      .dy       (dy0_ff),
      .fx       (fx0_ff),
      .fy       (fy0_ff),
      .angle    (angle_w),
      .is_right (right_w)
   );

   // delay the angle results to meet the direction results
   logic [tba_pkg::ANGLE_BITS-1:0] ang_pad_ff   [0:PAD-1];
   logic                           right_pad_ff [0:PAD-1];

   always_ff @(posedge clock) begin
      if (en) begin
         ang_pad_ff[0]   <= angle_w;
         right_pad_ff[0] <= right_w;
      end
   end

   for (genvar p = 1; p < PAD; p++) begin : g_pad
      always_ff @(posedge clock) begin
         if (en) begin
            ang_pad_ff[p]   <= ang_pad_ff[p-1];
            right_pad_ff[p] <= right_pad_ff[p-1];
         end
      end
   end

   // output register
   logic signed [OW-1:0]           dir_x_ff, dir_y_ff;
   logic [tba_pkg::ANGLE_BITS-1:0] angle_ff;
   logic                           is_right_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vld_ff[LD];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dir_x_ff    <= ux_w;
         dir_y_ff    <= uy_w;
         angle_ff    <= ang_pad_ff[PAD-1];
         is_right_ff <= right_pad_ff[PAD-1];
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.dir_x     = dir_x_ff;
   assign rsp_ch.dir_y     = dir_y_ff;
   assign rsp_ch.angle_deg = angle_ff;
   assign rsp_ch.is_right  = is_right_ff;

endmodule

`default_nettype wire
